@@ sv/asi_avg_pkg.sv @@
// shared constants and types for the sleep interval averager
`timescale 1ns / 1ps
package asi_avg_pkg;

  localparam int VAL_W            = 16;
  localparam int ATT_W            = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_W            = 16;
  localparam int SAMPLE_COUNT_DEF = 8;
  localparam int SUM_W_DEF        = VAL_W + $clog2(SAMPLE_COUNT_DEF);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AT_MAX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATT  = 2'd2;

  // operation codes
  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register reset values
  localparam logic [VAL_W-1:0] BASE_RST    = 16'd40;
  localparam logic [VAL_W-1:0] AT_MAX_RST  = 16'd300;
  localparam logic [ATT_W-1:0] MAX_ATT_RST = 8'd6;

  typedef logic [VAL_W-1:0] interval_t;

endpackage

@@ sv/asi_avg_if.sv @@
// request and result channel interfaces for the sleep interval averager
`timescale 1ns / 1ps
interface asi_avg_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [asi_avg_pkg::VAL_W-1:0]    fill_value;
  logic [asi_avg_pkg::ATT_W-1:0]    attempts;

  modport source (output valid, output operation, output fill_value, output attempts,
                  input ready);
  modport sink (input valid, input operation, input fill_value, input attempts,
                output ready);
endinterface

interface asi_avg_out_if;
  logic                             valid;
  logic                             ready;
  logic [asi_avg_pkg::VAL_W-1:0]    average_interval;

  modport source (output valid, output average_interval, input ready);
  modport sink (input valid, input average_interval, output ready);
endinterface

@@ sv/adaptive_sleep_interval_average.sv @@
// top level: moving average of sleep intervals held in a ring
// sequence: a fill request goes straight to the output register; a sample request
//   runs the bit-serial divider twice, which serves first the interval division
//   and then the division by the slot count
// requests: one at a time; the next is taken as soon as the result is loaded into
//   the output register, so no new request is taken while one is still in progress
// reset: synchronous, active high; registers to 40 / 300 / 6, ring reads as zero, sum and
//   slot pointer zero; no clearing pass, ring valid bits cleared at once
`timescale 1ns / 1ps
module adaptive_sleep_interval_average
  import asi_avg_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  asi_avg_in_if.sink           sample_ch,
  asi_avg_out_if.source        result_ch
);

  localparam int SUM_W   = VAL_W + $clog2(SAMPLE_COUNT);
  localparam int SLOT_W  = $clog2(SAMPLE_COUNT);
  localparam int CNT_W   = $clog2(SUM_W + 1);
  localparam int SUM_MAX = SAMPLE_COUNT * ((1 << VAL_W) - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1; // ring read back, product formed, divide starts
  localparam logic [2:0] ST_DIV1 = 3'd2; // interval division running
  localparam logic [2:0] ST_AVG  = 3'd3; // sum updated, mean division starts
  localparam logic [2:0] ST_DIV2 = 3'd4; // mean division running
  localparam logic [2:0] ST_PUT  = 3'd5; // result waits for the output register

  // configuration registers
  interval_t         base;
  interval_t         at_max;
  logic [ATT_W-1:0]  max_att;

  // control state
  logic [2:0]              st;
  logic [SLOT_W-1:0]       write_slot;
  logic [SAMPLE_COUNT-1:0] ring_valid;
  interval_t               fill_reg;
  logic [SUM_W-1:0]        ring_sum;
  logic                    out_valid;

  // datapath registers
  interval_t         ring [SAMPLE_COUNT];
  interval_t         ring_rd;
  interval_t         old_val;
  logic [ATT_W-1:0]  att_reg;
  interval_t         res;
  interval_t         out_data;

  // combinational
  logic                   accept;
  interval_t              span;
  logic [VAL_W+ATT_W-1:0] prod_full;
  interval_t              new_val;
  logic                   ring_we;
  logic                   div_start;
  logic [CNT_W-1:0]       div_steps;
  logic [SUM_W-1:0]       div_dend;
  logic [ATT_W-1:0]       div_dsor;
  logic                   div_busy;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quo;

  assign sample_ch.ready          = (st == ST_IDLE);
  assign accept                   = sample_ch.valid && sample_ch.ready;
  assign result_ch.valid          = out_valid;
  assign result_ch.average_interval = out_data;

  // span and product wrap at 16 bits
  assign span      = at_max - base;
  assign prod_full = span * att_reg;
  assign new_val   = div_quo[VAL_W-1:0] + base;
  assign ring_we   = (st == ST_DIV1) && div_done;

  // shared divider: first the scaled attempts, then the ring sum by the slot count
  always_comb begin
    div_start = (st == ST_MUL) || (st == ST_AVG);
    if (st == ST_MUL) begin
      div_steps = CNT_W'(VAL_W);
      div_dend  = {prod_full[VAL_W-1:0], {(SUM_W-VAL_W){1'b0}}};
      div_dsor  = max_att;
    end else begin
      div_steps = CNT_W'(SUM_W);
      div_dend  = ring_sum;
      div_dsor  = ATT_W'(SAMPLE_COUNT);
    end
  end

  asi_avg_div #(
    .DEND_W (SUM_W),
    .DSOR_W (ATT_W),
    .CNT_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .dividend (div_dend),
    .divisor  (div_dsor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= BASE_RST;
      at_max  <= AT_MAX_RST;
      max_att <= MAX_ATT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:    base    <= cfg_data[VAL_W-1:0];
        REG_AT_MAX:  at_max  <= cfg_data[VAL_W-1:0];
        REG_MAX_ATT: max_att <= cfg_data[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  // ring memory, one write and one registered read at the slot pointer
  always_ff @(posedge clk) begin
    ring_rd <= ring[write_slot];
    if (ring_we) begin
      ring[write_slot] <= new_val;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      write_slot <= '0;
      ring_valid <= '0;
      fill_reg   <= '0;
      ring_sum   <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (accept) begin
            if (sample_ch.operation == OP_FILL) begin
              // a fill marks every slot stale; stale slots read as the fill value
              ring_valid <= '0;
              fill_reg   <= sample_ch.fill_value;
              ring_sum   <= SUM_W'(sample_ch.fill_value * SAMPLE_COUNT);
              st         <= ST_PUT;
            end else begin
              st <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          st <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_done) begin
            ring_valid[write_slot] <= 1'b1;
            ring_sum   <= ring_sum - SUM_W'(old_val) + SUM_W'(new_val);
            write_slot <= (write_slot == SLOT_W'(SAMPLE_COUNT - 1)) ? '0
                          : write_slot + SLOT_W'(1);
            st         <= ST_AVG;
          end
        end
        ST_AVG: begin
          st <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div_done) begin
            st <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (!out_valid || result_ch.ready) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      att_reg <= sample_ch.attempts;
      res     <= sample_ch.fill_value;
    end
    if (st == ST_MUL) begin
      old_val <= ring_valid[write_slot] ? ring_rd : fill_reg;
    end
    if (st == ST_DIV2 && div_done) begin
      res <= div_quo[VAL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_PUT && (!out_valid || result_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_PUT && (!out_valid || result_ch.ready)) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  // divider is never restarted mid-division
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // running sum never exceeds a ring of full-scale intervals
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    ring_sum <= SUM_W'(SUM_MAX))
    else $error("ring sum out of range");

  // a fill request yields its own value as the mean
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    (accept && sample_ch.operation == OP_FILL)
      |=> (st == ST_PUT && res == $past(sample_ch.fill_value)))
    else $error("fill result mismatch");
`endif

endmodule

@@ sv/asi_avg_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module asi_avg_div
  import asi_avg_pkg::*;
#(
  parameter int DEND_W = SUM_W_DEF,
  parameter int DSOR_W = ATT_W,
  parameter int CNT_W  = $clog2(SUM_W_DEF + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CNT_W-1:0]  steps,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DSOR_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DEND_W-1:0] quotient
);

  logic [CNT_W-1:0]  cnt;
  logic [DEND_W-1:0] dend;
  logic [DSOR_W-1:0] rem;
  logic [DSOR_W-1:0] dsor;
  logic [DSOR_W:0]   trial;
  logic [DSOR_W:0]   diff;
  logic              q_bit;
  logic [DSOR_W-1:0] rem_next;

  // zero divisor gives all ones, the trial always fits
  always_comb begin
    trial    = {rem, dend[DEND_W-1]};
    diff     = trial - {1'b0, dsor};
    q_bit    = (trial >= {1'b0, dsor});
    rem_next = q_bit ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= steps;
      dend     <= dividend;
      dsor     <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      cnt      <= cnt - CNT_W'(1);
      dend     <= {dend[DEND_W-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[DEND_W-2:0], q_bit};
    end
  end

endmodule
